[src/dtwr_pkg.sv]
// Shared widths, status codes and the divider item type for the ranging distance unit.
// No dependencies; every other file in src imports this package.
package dtwr_pkg;

    localparam int TS_BITS   = 40;
    localparam int DIST_BITS = 32;
    localparam int TAG_W     = 8;
    localparam int SCALE_W   = 24;
    localparam int FRAC_W    = 16;
    localparam int STAT_W    = 2;

    // Stream widths: packed fields filled up to whole bytes.
    localparam int IN_W      = ((TAG_W + 5 * TS_BITS + 7) / 8) * 8;
    localparam int OUT_W     = ((TAG_W + DIST_BITS + 7) / 8) * 8;

    localparam int LO_W      = (TS_BITS + 1) / 2;
    localparam int HI_W      = TS_BITS - LO_W;
    localparam int PROD_W    = 2 * TS_BITS;
    localparam int DEN_W     = TS_BITS + 2;
    localparam int SEG_W     = (PROD_W + 2) / 3;
    localparam int NS_W      = PROD_W + SCALE_W;
    localparam int DD_W      = DEN_W + FRAC_W;
    localparam int Q_W       = DIST_BITS + 1;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT      = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd307388;

    localparam logic [DIST_BITS-1:0] DIST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};
    localparam logic [DIST_BITS-1:0] DIST_MIN = {1'b1, {(DIST_BITS-1){1'b0}}};

    // One item in flight through the divider.
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             neg;
        logic             zero;
        logic             ovf;
        logic [DD_W-1:0]  dd;
        logic [DD_W-1:0]  rem;
        logic [Q_W-1:0]   q;
        logic [Q_W-1:0]   low;
    } div_t;

endpackage

[src/dtwr_prod.sv]
// Front stages: reply derivation, denominator, split products and their difference.
// Depends on dtwr_pkg.
module dtwr_prod (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        ce,
    input  logic                        in_valid,
    input  logic [dtwr_pkg::TAG_W-1:0]   in_tag,
    input  logic [dtwr_pkg::TS_BITS-1:0] first_round,
    input  logic [dtwr_pkg::TS_BITS-1:0] first_reply,
    input  logic [dtwr_pkg::TS_BITS-1:0] second_round,
    input  logic [dtwr_pkg::TS_BITS-1:0] poll_sent_at,
    input  logic [dtwr_pkg::TS_BITS-1:0] final_sent_at,
    output logic                        out_valid,
    output logic [dtwr_pkg::TAG_W-1:0]   out_tag,
    output logic [dtwr_pkg::PROD_W-1:0]  out_mag,
    output logic                        out_neg,
    output logic [dtwr_pkg::DEN_W-1:0]   out_den
);
    import dtwr_pkg::*;

    logic [3:0]          vld_reg;
    logic [TAG_W-1:0]    tag_a_reg, tag_b_reg, tag_c_reg, tag_d_reg;
    logic [TS_BITS-1:0]  r1_reg, p1_reg, r2_reg, p2_reg;
    logic [TS_BITS-1:0]  p2_next;
    logic [DEN_W-1:0]    den_b_reg, den_c_reg, den_d_reg, den_b_next;
    logic [2*LO_W-1:0]   all_reg, bll_reg;
    logic [LO_W+HI_W-1:0] alh_reg, ahl_reg, blh_reg, bhl_reg;
    logic [2*HI_W-1:0]   ahh_reg, bhh_reg;
    logic [PROD_W-1:0]   pa_reg, pb_reg, pa_next, pb_next;
    logic [PROD_W-1:0]   mag_reg, mag_next;
    logic                neg_reg, neg_next;

    // Second reply time, modulo the timestamp width.
    assign p2_next = final_sent_at - (poll_sent_at + first_round);

    assign den_b_next = DEN_W'(r1_reg) + DEN_W'(r2_reg) + DEN_W'(p1_reg) + DEN_W'(p2_reg);

    assign pa_next = PROD_W'(all_reg) + (PROD_W'(alh_reg) << LO_W) + (PROD_W'(ahl_reg) << LO_W)
                   + (PROD_W'(ahh_reg) << (2 * LO_W));
    assign pb_next = PROD_W'(bll_reg) + (PROD_W'(blh_reg) << LO_W) + (PROD_W'(bhl_reg) << LO_W)
                   + (PROD_W'(bhh_reg) << (2 * LO_W));

    always_comb
    begin
        neg_next = (pa_reg < pb_reg);
        mag_next = neg_next ? (pb_reg - pa_reg) : (pa_reg - pb_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            tag_a_reg <= in_tag;
            r1_reg    <= first_round;
            p1_reg    <= first_reply;
            r2_reg    <= second_round;
            p2_reg    <= p2_next;

            tag_b_reg <= tag_a_reg;
            den_b_reg <= den_b_next;
            all_reg   <= r1_reg[LO_W-1:0] * r2_reg[LO_W-1:0];
            alh_reg   <= r1_reg[LO_W-1:0] * r2_reg[TS_BITS-1:LO_W];
            ahl_reg   <= r1_reg[TS_BITS-1:LO_W] * r2_reg[LO_W-1:0];
            ahh_reg   <= r1_reg[TS_BITS-1:LO_W] * r2_reg[TS_BITS-1:LO_W];
            bll_reg   <= p1_reg[LO_W-1:0] * p2_reg[LO_W-1:0];
            blh_reg   <= p1_reg[LO_W-1:0] * p2_reg[TS_BITS-1:LO_W];
            bhl_reg   <= p1_reg[TS_BITS-1:LO_W] * p2_reg[LO_W-1:0];
            bhh_reg   <= p1_reg[TS_BITS-1:LO_W] * p2_reg[TS_BITS-1:LO_W];

            tag_c_reg <= tag_b_reg;
            den_c_reg <= den_b_reg;
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;

            tag_d_reg <= tag_c_reg;
            den_d_reg <= den_c_reg;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
        end
    end

    assign out_valid = vld_reg[3];
    assign out_tag   = tag_d_reg;
    assign out_mag   = mag_reg;
    assign out_neg   = neg_reg;
    assign out_den   = den_d_reg;

endmodule

[src/dtwr_scale.sv]
// Middle stages: scaling of the numerator, divisor set-up and quotient range check.
// Depends on dtwr_pkg.
module dtwr_scale (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        ce,
    input  logic                        in_valid,
    input  logic [dtwr_pkg::TAG_W-1:0]   in_tag,
    input  logic [dtwr_pkg::PROD_W-1:0]  in_mag,
    input  logic                        in_neg,
    input  logic [dtwr_pkg::DEN_W-1:0]   in_den,
    input  logic [dtwr_pkg::SCALE_W-1:0] scale,
    output logic                        out_valid,
    output dtwr_pkg::div_t              out_item
);
    import dtwr_pkg::*;

    logic [2:0]               vld_reg;
    logic [3*SEG_W-1:0]       mag_ext;
    logic [TAG_W-1:0]         tag_e_reg, tag_f_reg;
    logic                     neg_e_reg, neg_f_reg;
    logic [DEN_W-1:0]         den_e_reg;
    logic [SEG_W+SCALE_W-1:0] s0_reg, s1_reg, s2_reg;
    logic [NS_W-1:0]          ns_reg, ns_next;
    logic [DD_W-1:0]          dd_reg;
    logic                     zero_reg;
    div_t                     item_reg, item_next;

    assign mag_ext = (3*SEG_W)'(in_mag);

    assign ns_next = NS_W'(s0_reg) + (NS_W'(s1_reg) << SEG_W) + (NS_W'(s2_reg) << (2 * SEG_W));

    // A quotient that needs more than Q_W bits is out of range whatever its value.
    always_comb
    begin
        item_next.tag  = tag_f_reg;
        item_next.neg  = neg_f_reg;
        item_next.zero = zero_reg;
        item_next.ovf  = (ns_reg[NS_W-1:Q_W] >= (NS_W-Q_W)'(dd_reg));
        item_next.dd   = dd_reg;
        item_next.rem  = DD_W'(ns_reg[NS_W-1:Q_W]);
        item_next.q    = '0;
        item_next.low  = ns_reg[Q_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            tag_e_reg <= in_tag;
            neg_e_reg <= in_neg;
            den_e_reg <= in_den;
            s0_reg    <= mag_ext[SEG_W-1:0] * scale;
            s1_reg    <= mag_ext[2*SEG_W-1:SEG_W] * scale;
            s2_reg    <= mag_ext[3*SEG_W-1:2*SEG_W] * scale;

            tag_f_reg <= tag_e_reg;
            neg_f_reg <= neg_e_reg;
            ns_reg    <= ns_next;
            dd_reg    <= {den_e_reg, {FRAC_W{1'b0}}};
            zero_reg  <= (den_e_reg == '0);

            item_reg  <= item_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_item  = item_reg;

endmodule

[src/dtwr_div.sv]
// Restoring divider, one quotient bit per pipeline stage.
// Depends on dtwr_pkg.
module dtwr_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           ce,
    input  logic           in_valid,
    input  dtwr_pkg::div_t in_item,
    output logic           out_valid,
    output dtwr_pkg::div_t out_item
);
    import dtwr_pkg::*;

    logic [Q_W-1:0] vld_reg;
    div_t           stg_reg [Q_W];
    div_t           stg_next [Q_W];
    div_t           stg_prev [Q_W];

    genvar i;
    generate
        for (i = 0; i < Q_W; i++)
        begin : g_step
            logic [DD_W:0] trial;
            logic          ge;

            if (i == 0)
            begin : g_first
                assign stg_prev[i] = in_item;
            end
            else
            begin : g_rest
                assign stg_prev[i] = stg_reg[i-1];
            end

            assign trial = {stg_prev[i].rem, stg_prev[i].low[Q_W-1]};
            assign ge    = (trial >= {1'b0, stg_prev[i].dd});

            always_comb
            begin
                stg_next[i]     = stg_prev[i];
                stg_next[i].rem = ge ? DD_W'(trial - {1'b0, stg_prev[i].dd}) : DD_W'(trial);
                stg_next[i].q   = {stg_prev[i].q[Q_W-2:0], ge};
                stg_next[i].low = {stg_prev[i].low[Q_W-2:0], 1'b0};
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    stg_reg[i] <= stg_next[i];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[Q_W-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign out_item  = stg_reg[Q_W-1];

endmodule

[src/ds_twr_distance_calc.sv]
// Top level of the double-sided two-way ranging distance unit.
// Depends on dtwr_pkg, dtwr_prod, dtwr_scale and dtwr_div.
//
// Usage:
//   Each item on the slave stream carries one peer's timing set. The unit derives
//   the peer's second reply time modulo 2^40, forms the flight time
//   (round1*round2 - reply1*reply2) / (sum of the four durations), scales it by
//   mm_per_tick_q16 / 65536, floors it and saturates it to 32 bits signed.
//   The master stream returns exactly one item per input item, in order.
// Throughput: one item per clock cycle, sustained while m_tready stays high.
// Pipeline: 41 register stages, the first loaded at the accepting edge: four front
//   stages (input and reply, denominator and partial products, product sum,
//   difference), three scaling stages, 33 divider stages (one quotient bit each)
//   and the output register.
// Stall: the whole pipeline advances only when the output register is empty or is
//   being taken; s_tready is high exactly then, so nothing is lost or
//   repeated while the receiver holds off.
// Reset: rst_n clears every valid bit and loads the scale register with 307388.
// Configuration: cfg_we writes cfg_wdata into the scale register; it should only be
//   written while no item is in flight.
module ds_twr_distance_calc (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [dtwr_pkg::SCALE_W-1:0] cfg_wdata,     // mm_per_tick_q16
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // peer_tag[7:0], first_round[47:8], first_reply[87:48], second_round[127:88],
    // poll_sent_at[167:128], final_sent_at[207:168]
    input  logic [dtwr_pkg::IN_W-1:0]    s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [dtwr_pkg::OUT_W-1:0]   m_tdata,       // peer_tag_out[7:0], distance_mm[39:8]
    output logic [dtwr_pkg::STAT_W-1:0]  m_tuser        // status[1:0]
);
    import dtwr_pkg::*;

    logic                 ce;
    logic [SCALE_W-1:0]   scale_reg;
    logic                 prod_valid, scale_valid, div_valid;
    logic [TAG_W-1:0]     prod_tag;
    logic [PROD_W-1:0]    prod_mag;
    logic                 prod_neg;
    logic [DEN_W-1:0]     prod_den;
    div_t                 scale_item, div_item;

    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_data_reg, out_data_next;
    logic [STAT_W-1:0]    out_stat_reg, out_stat_next;

    logic [Q_W:0]         mag;
    logic [DIST_BITS-1:0] dist_val;

    // The pipeline moves whenever the output register can take a new item.
    assign ce       = !out_valid_reg || m_tready;
    assign s_tready = ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            scale_reg <= cfg_wdata;
        end
    end

    dtwr_prod u_prod (
        .clk           (clk),
        .rst_n         (rst_n),
        .ce            (ce),
        .in_valid      (s_tvalid && ce),
        .in_tag        (s_tdata[TAG_W-1:0]),
        .first_round   (s_tdata[TAG_W +: TS_BITS]),
        .first_reply   (s_tdata[TAG_W + TS_BITS +: TS_BITS]),
        .second_round  (s_tdata[TAG_W + 2 * TS_BITS +: TS_BITS]),
        .poll_sent_at  (s_tdata[TAG_W + 3 * TS_BITS +: TS_BITS]),
        .final_sent_at (s_tdata[TAG_W + 4 * TS_BITS +: TS_BITS]),
        .out_valid     (prod_valid),
        .out_tag       (prod_tag),
        .out_mag       (prod_mag),
        .out_neg       (prod_neg),
        .out_den       (prod_den)
    );

    dtwr_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (prod_valid),
        .in_tag    (prod_tag),
        .in_mag    (prod_mag),
        .in_neg    (prod_neg),
        .in_den    (prod_den),
        .scale     (scale_reg),
        .out_valid (scale_valid),
        .out_item  (scale_item)
    );

    dtwr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (scale_valid),
        .in_item   (scale_item),
        .out_valid (div_valid),
        .out_item  (div_item)
    );

    // A negative value with a remainder rounds one further from zero, which is the
    // floor. The magnitude then saturates against the signed range.
    always_comb
    begin
        mag = (Q_W+1)'(div_item.q)
            + (Q_W+1)'(div_item.neg && (div_item.rem != '0));
        out_stat_next = ST_OK;
        if (div_item.zero)
        begin
            dist_val      = '0;
            out_stat_next = ST_ZERO_DEN;
        end
        else if (div_item.neg)
        begin
            if (div_item.ovf || (mag > (Q_W+1)'(DIST_MIN)))
            begin
                dist_val      = DIST_MIN;
                out_stat_next = ST_SAT;
            end
            else
            begin
                dist_val = DIST_BITS'((~mag) + 1'b1);
            end
        end
        else
        begin
            if (div_item.ovf || (mag > (Q_W+1)'(DIST_MAX)))
            begin
                dist_val      = DIST_MAX;
                out_stat_next = ST_SAT;
            end
            else
            begin
                dist_val = DIST_BITS'(mag);
            end
        end
        out_data_next = OUT_W'({dist_val, div_item.tag});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            out_data_reg <= out_data_next;
            out_stat_reg <= out_stat_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_stat_reg;

endmodule

[src/dtwr_checker.sv]
// Port-level checks for the ranging distance unit, bound to the top level.
// Depends on dtwr_pkg and ds_twr_distance_calc.
module dtwr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [dtwr_pkg::OUT_W-1:0]  m_tdata,
    input logic [dtwr_pkg::STAT_W-1:0] m_tuser
);
    import dtwr_pkg::*;

    // A held result stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Input is taken exactly when the output side can move.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not track output");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_ZERO_DEN || m_tuser == ST_SAT))
        else $error("unused status code");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_ZERO_DEN) |-> (m_tdata[TAG_W +: DIST_BITS] == '0))
        else $error("zero denominator with nonzero distance");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_SAT) |->
            (m_tdata[TAG_W +: DIST_BITS] == DIST_MAX || m_tdata[TAG_W +: DIST_BITS] == DIST_MIN))
        else $error("saturated distance not at a limit");

endmodule

bind ds_twr_distance_calc dtwr_checker u_dtwr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
